FILE: src/dgd_pkg.sv
// Shared types, constants and MD5 tables for the datagram deobfuscator.
package dgd_pkg;

    localparam logic [31:0] SYNC_WORD = 32'h13EF24D5;
    localparam logic [7:0]  KEY_TAG   = 8'hA5;
    localparam logic [4:0]  HDR_LEN   = 5'd8;
    localparam logic [3:0]  PAD_MASK  = 4'hF;
    localparam logic [7:0]  OPC_RESET = 8'd227;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_OPCODE = 1'b1;

    localparam logic [31:0] MD5_A0 = 32'h67452301;
    localparam logic [31:0] MD5_B0 = 32'hefcdab89;
    localparam logic [31:0] MD5_C0 = 32'h98badcfe;
    localparam logic [31:0] MD5_D0 = 32'h10325476;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] base_key;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       was_decrypted;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] key;
        logic [7:0]  b1;
        logic [7:0]  b2;
    } t_md5_ctl;

    typedef struct packed {
        logic         done;
        logic [127:0] digest;
    } t_md5_sts;

    typedef struct packed {
        logic         setup;
        logic         next;
        logic [127:0] key;
    } t_rc4_ctl;

    typedef struct packed {
        logic       done;
        logic [7:0] ks;
    } t_rc4_sts;

    function automatic logic [4:0] md5_rot(input logic [3:0] idx);
        logic [4:0] r;
        unique case (idx)
            4'd0:  r = 5'd7;
            4'd1:  r = 5'd12;
            4'd2:  r = 5'd17;
            4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;
            4'd5:  r = 5'd9;
            4'd6:  r = 5'd14;
            4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;
            4'd9:  r = 5'd11;
            4'd10: r = 5'd16;
            4'd11: r = 5'd23;
            4'd12: r = 5'd6;
            4'd13: r = 5'd10;
            4'd14: r = 5'd15;
            default: r = 5'd21;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] r;
        unique case (idx)
            6'd0:  r = 32'hd76aa478; 6'd1:  r = 32'he8c7b756;
            6'd2:  r = 32'h242070db; 6'd3:  r = 32'hc1bdceee;
            6'd4:  r = 32'hf57c0faf; 6'd5:  r = 32'h4787c62a;
            6'd6:  r = 32'ha8304613; 6'd7:  r = 32'hfd469501;
            6'd8:  r = 32'h698098d8; 6'd9:  r = 32'h8b44f7af;
            6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
            6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193;
            6'd14: r = 32'ha679438e; 6'd15: r = 32'h49b40821;
            6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
            6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa;
            6'd20: r = 32'hd62f105d; 6'd21: r = 32'h02441453;
            6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
            6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6;
            6'd26: r = 32'hf4d50d87; 6'd27: r = 32'h455a14ed;
            6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
            6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a;
            6'd32: r = 32'hfffa3942; 6'd33: r = 32'h8771f681;
            6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
            6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9;
            6'd38: r = 32'hf6bb4b60; 6'd39: r = 32'hbebfbc70;
            6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
            6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05;
            6'd44: r = 32'hd9d4d039; 6'd45: r = 32'he6db99e5;
            6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
            6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97;
            6'd50: r = 32'hab9423a7; 6'd51: r = 32'hfc93a039;
            6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
            6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1;
            6'd56: r = 32'h6fa87e4f; 6'd57: r = 32'hfe2ce6e0;
            6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
            6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235;
            6'd62: r = 32'h2ad7d2bb;
            default: r = 32'heb86d391;
        endcase
        return r;
    endfunction

endpackage

FILE: src/dgd_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
interface dgd_stream_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/dgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/dgd_md5.sv
// Iterative single-block MD5 for the seven-byte packet key message.
module dgd_md5 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dgd_pkg::t_md5_ctl i_ctl,
    output dgd_pkg::t_md5_sts o_sts
);
    import dgd_pkg::*;

    logic        r_busy;
    logic        r_fin;
    logic [5:0]  r_k;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_w0, r_w1;

    logic [3:0]  w_k4;
    logic [3:0]  w_g;
    logic [31:0] w_f;
    logic [31:0] w_wg;
    logic [31:0] w_t;
    logic [63:0] w_rot;

    always_comb begin
        w_k4 = r_k[3:0];
        unique case (r_k[5:4])
            2'd0: begin
                w_f = (r_b & r_c) | (~r_b & r_d);
                w_g = w_k4;
            end
            2'd1: begin
                w_f = (r_d & r_b) | (~r_d & r_c);
                w_g = {w_k4[1:0], 2'b00} + w_k4 + 4'd1;
            end
            2'd2: begin
                w_f = r_b ^ r_c ^ r_d;
                w_g = {w_k4[2:0], 1'b0} + w_k4 + 4'd5;
            end
            default: begin
                w_f = r_c ^ (r_b | ~r_d);
                w_g = {w_k4[0], 3'b000} - w_k4;
            end
        endcase
        priority if (w_g == 4'd0) begin
            w_wg = r_w0;
        end else if (w_g == 4'd1) begin
            w_wg = r_w1;
        end else if (w_g == 4'd14) begin
            w_wg = 32'd56;
        end else begin
            w_wg = 32'd0;
        end
        w_t   = r_a + w_f + md5_k(r_k) + w_wg;
        w_rot = {w_t, w_t} << md5_rot({r_k[5:4], r_k[1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_k    <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_a    <= MD5_A0;
                r_b    <= MD5_B0;
                r_c    <= MD5_C0;
                r_d    <= MD5_D0;
                r_w0   <= i_ctl.key;
                r_w1   <= {8'h80, i_ctl.b2, i_ctl.b1, KEY_TAG};
            end else if (r_busy) begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + w_rot[63:32];
                r_k <= r_k + 6'd1;
                if (r_k == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done   = r_fin;
    assign o_sts.digest = {MD5_D0 + r_d, MD5_C0 + r_c, MD5_B0 + r_b, MD5_A0 + r_a};
endmodule

FILE: src/dgd_rc4.sv
// RC4 key schedule and keystream sequencer around the S-box memory.
module dgd_rc4 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dgd_pkg::t_rc4_ctl i_ctl,
    output dgd_pkg::t_rc4_sts o_sts
);
    import dgd_pkg::*;

    typedef enum logic [3:0] {
        R_IDLE, R_INIT, R_KA, R_KB, R_KC, R_KD,
        R_NA, R_NB, R_NC, R_ND, R_NE, R_NF
    } t_rstate;

    t_rstate      r_state;
    logic [127:0] r_key;
    logic [7:0]   r_k;
    logic [7:0]   r_i;
    logic [7:0]   r_j;
    logic [7:0]   r_sa;
    logic [7:0]   r_sb;
    logic         r_done;
    logic [7:0]   r_ks;

    logic       w_we;
    logic [7:0] w_waddr;
    logic [7:0] w_wdata;
    logic [7:0] w_raddr;
    logic [7:0] w_rdata;
    logic [7:0] w_kbyte;

    dgd_ram #(.WIDTH(8), .DEPTH(256)) u_sbox (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_kbyte = r_key[{r_k[3:0], 3'b000} +: 8];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_k;
        w_wdata = r_k;
        w_raddr = r_k;
        unique case (r_state)
            R_INIT: w_we = 1'b1;
            R_KB:   w_raddr = r_j + w_rdata + w_kbyte;
            R_KC: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            R_KD: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_sa;
            end
            R_NA:   w_raddr = r_i + 8'd1;
            R_NB:   w_raddr = r_j + w_rdata;
            R_NC: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
            end
            R_ND: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_sa;
            end
            R_NE:   w_raddr = r_sa + r_sb;
            default: w_raddr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                R_IDLE: begin
                    if (i_ctl.setup) begin
                        r_key   <= i_ctl.key;
                        r_k     <= '0;
                        r_state <= R_INIT;
                    end else if (i_ctl.next) begin
                        r_state <= R_NA;
                    end
                end
                R_INIT: begin
                    r_k <= r_k + 8'd1;
                    if (r_k == 8'd255) begin
                        r_j     <= '0;
                        r_state <= R_KA;
                    end
                end
                R_KA: r_state <= R_KB;
                R_KB: begin
                    r_sa    <= w_rdata;
                    r_j     <= w_raddr;
                    r_state <= R_KC;
                end
                R_KC: r_state <= R_KD;
                R_KD: begin
                    r_k <= r_k + 8'd1;
                    if (r_k == 8'd255) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_done  <= 1'b1;
                        r_state <= R_IDLE;
                    end else begin
                        r_state <= R_KA;
                    end
                end
                R_NA: begin
                    r_i     <= w_raddr;
                    r_state <= R_NB;
                end
                R_NB: begin
                    r_sa    <= w_rdata;
                    r_j     <= w_raddr;
                    r_state <= R_NC;
                end
                R_NC: begin
                    r_sb    <= w_rdata;
                    r_state <= R_ND;
                end
                R_ND: r_state <= R_NE;
                R_NE: r_state <= R_NF;
                R_NF: begin
                    r_ks    <= w_rdata;
                    r_done  <= 1'b1;
                    r_state <= R_IDLE;
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.ks   = r_ks;
endmodule

FILE: src/server_datagram_deobfuscator_top.sv
// Top level: packet control, hold buffer and output register of the deobfuscator.
//
// One byte is processed at a time. A decrypted byte waits for the RC4 step in the
// one-write, one-read S-box memory (two reads, two write-back steps of the swap, one
// keystream read and its capture, then done), as does a held byte that draws keystream.
// Byte 2 of a candidate packet runs MD5 and the RC4 key schedule (a fill pass and a
// swap pass) before the next byte is taken. Held bytes of a rejected or short packet
// are flushed from the hold memory, one read step and one write step per byte. Output
// stalls hold pass-through, decrypted and flushed bytes.
// No clearing pass runs after reset.
// Configuration is sampled on the first byte.
module server_datagram_deobfuscator_top #(
    parameter int MAX_PAD    = 15,
    parameter int HOLD_DEPTH = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    dgd_stream_if.sink   i_in,
    dgd_stream_if.source o_out
);
    import dgd_pkg::*;

    localparam int AW = $clog2(HOLD_DEPTH);

    typedef enum logic [1:0] {PH_IDLE, PH_PASS, PH_HOLD, PH_DEC} t_phase;
    typedef enum logic [3:0] {
        T_IN, T_PASS, T_KS, T_MD5, T_SETUP, T_DEC, T_END, T_FL_RD, T_FL_WR, T_FIN
    } t_state;

    t_state      r_state;
    t_phase      r_phase;
    logic        r_en;
    logic [7:0]  r_opc;
    logic [4:0]  r_pos;
    logic [4:0]  r_fi;
    logic [3:0]  r_pad;
    logic [23:0] r_magic;
    logic [31:0] r_key;
    logic [7:0]  r_b1;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [7:0]  r_dec;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ol;
    logic        r_od;

    t_in_item  w_in;
    t_out_item w_out;
    t_md5_ctl  w_md5_ctl;
    t_md5_sts  w_md5_sts;
    t_rc4_ctl  w_rc4_ctl;
    t_rc4_sts  w_rc4_sts;
    logic      w_acc;
    t_phase    w_phase;
    logic [4:0] w_pos;
    logic      w_hwe;
    logic [7:0] w_hrd;
    logic      w_slot;
    logic      w_load;
    logic [7:0] w_d;
    logic [3:0] w_pad;
    logic      w_in_depth;

    assign w_in  = i_in.payload;
    assign w_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == T_IN);
    assign w_slot = !r_ov || o_out.ready;
    assign w_load = w_slot &&
                    (r_state == T_PASS || r_state == T_DEC || r_state == T_FL_WR);

    always_comb begin
        if (r_phase == PH_IDLE) begin
            w_pos = '0;
            if (!r_en || w_in.base_key == 32'd0 || w_in.data_byte == r_opc) begin
                w_phase = PH_PASS;
            end else begin
                w_phase = PH_HOLD;
            end
        end else begin
            w_pos   = r_pos;
            w_phase = r_phase;
        end
    end

    assign w_hwe = w_acc && (w_phase == PH_HOLD) && ({1'b0, w_pos} < 6'(HOLD_DEPTH));
    assign w_in_depth = ({1'b0, r_fi} < 6'(HOLD_DEPTH));

    dgd_ram #(.WIDTH(8), .DEPTH(HOLD_DEPTH)) u_hold (
        .i_clk  (i_clk),
        .i_we   (w_hwe),
        .i_waddr(w_pos[AW-1:0]),
        .i_wdata(w_in.data_byte),
        .i_raddr(r_fi[AW-1:0]),
        .o_rdata(w_hrd)
    );

    assign w_md5_ctl.start = w_acc && (w_phase == PH_HOLD) && (w_pos == 5'd2);
    assign w_md5_ctl.key   = r_key;
    assign w_md5_ctl.b1    = r_b1;
    assign w_md5_ctl.b2    = w_in.data_byte;

    assign w_rc4_ctl.setup = (r_state == T_MD5) && w_md5_sts.done;
    assign w_rc4_ctl.key   = w_md5_sts.digest;
    assign w_rc4_ctl.next  = w_acc && ((w_phase == PH_DEC) ||
                             ((w_phase == PH_HOLD) && (w_pos >= 5'd3)));

    dgd_md5 u_md5 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_md5_ctl),
        .o_sts  (w_md5_sts)
    );

    dgd_rc4 u_rc4 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_rc4_ctl),
        .o_sts  (w_rc4_sts)
    );

    assign w_d   = r_byte ^ w_rc4_sts.ks;
    assign w_pad = ((w_d[3:0] & PAD_MASK) > 4'(MAX_PAD)) ? 4'(MAX_PAD) : (w_d[3:0] & PAD_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_opc <= OPC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE: r_en  <= i_cfg_data[0];
                default:    r_opc <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IN;
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_pad   <= '0;
            r_fi    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                T_IN: begin
                    if (w_acc) begin
                        r_byte  <= w_in.data_byte;
                        r_last  <= w_in.last_byte;
                        r_pos   <= w_pos;
                        r_phase <= w_phase;
                        if (r_phase == PH_IDLE) begin
                            r_key <= w_in.base_key;
                        end
                        if (w_pos == 5'd1) begin
                            r_b1 <= w_in.data_byte;
                        end
                        priority if (w_phase == PH_PASS) begin
                            r_state <= T_PASS;
                        end else if (w_md5_ctl.start) begin
                            r_state <= T_MD5;
                        end else if (w_rc4_ctl.next) begin
                            r_state <= T_KS;
                        end else begin
                            r_state <= T_END;
                        end
                    end
                end
                T_PASS: begin
                    if (w_slot) begin
                        r_ob    <= r_byte;
                        r_ol    <= r_last;
                        r_od    <= 1'b0;
                        r_state <= T_END;
                    end
                end
                T_MD5: begin
                    if (w_md5_sts.done) begin
                        r_state <= T_SETUP;
                    end
                end
                T_SETUP: begin
                    if (w_rc4_sts.done) begin
                        r_magic <= '0;
                        r_state <= T_END;
                    end
                end
                T_KS: begin
                    if (w_rc4_sts.done) begin
                        r_dec <= w_d;
                        priority if (r_phase == PH_DEC) begin
                            r_state <= T_DEC;
                        end else if (r_pos == 5'd3) begin
                            r_magic[7:0] <= w_d;
                            r_state      <= T_END;
                        end else if (r_pos == 5'd4) begin
                            r_magic[15:8] <= w_d;
                            r_state       <= T_END;
                        end else if (r_pos == 5'd5) begin
                            r_magic[23:16] <= w_d;
                            r_state        <= T_END;
                        end else if (r_pos == 5'd6) begin
                            if ({w_d, r_magic} != SYNC_WORD) begin
                                r_phase <= PH_PASS;
                                r_fi    <= '0;
                                r_state <= T_FL_RD;
                            end else begin
                                r_state <= T_END;
                            end
                        end else if (r_pos == 5'd7) begin
                            r_pad   <= w_pad;
                            r_state <= T_END;
                        end else if (r_pos == HDR_LEN + {1'b0, r_pad}) begin
                            r_phase <= PH_DEC;
                            r_state <= T_DEC;
                        end else begin
                            r_state <= T_END;
                        end
                    end
                end
                T_DEC: begin
                    if (w_slot) begin
                        r_ob    <= r_dec;
                        r_ol    <= r_last;
                        r_od    <= 1'b1;
                        r_state <= T_END;
                    end
                end
                T_END: begin
                    if (r_phase == PH_HOLD && r_last) begin
                        r_fi    <= '0;
                        r_state <= T_FL_RD;
                    end else begin
                        r_state <= T_FIN;
                    end
                end
                T_FL_RD: r_state <= T_FL_WR;
                T_FL_WR: begin
                    if (w_slot) begin
                        r_ob <= w_in_depth ? w_hrd : 8'd0;
                        r_ol <= r_last && (r_fi == r_pos);
                        r_od <= 1'b0;
                        if (r_fi == r_pos) begin
                            r_state <= T_FIN;
                        end else begin
                            r_fi    <= r_fi + 5'd1;
                            r_state <= T_FL_RD;
                        end
                    end
                end
                T_FIN: begin
                    if (r_last) begin
                        r_phase <= PH_IDLE;
                        r_pos   <= '0;
                    end else if (r_pos != 5'd31) begin
                        r_pos <= r_pos + 5'd1;
                    end
                    r_state <= T_IN;
                end
                default: r_state <= T_IN;
            endcase
        end
    end

    assign w_out.out_byte      = r_ob;
    assign w_out.out_last      = r_ol;
    assign w_out.was_decrypted = r_od;
    assign o_out.valid   = r_ov;
    assign o_out.payload = w_out;

    a_rc4_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rc4_sts.done |-> (r_state == T_KS || r_state == T_SETUP))
        else $error("keystream unit finished outside a wait state");

    a_md5_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md5_sts.done |-> (r_state == T_MD5))
        else $error("digest finished outside its wait state");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_FL_WR) |-> (r_fi <= r_pos))
        else $error("flush index ran past held bytes");
endmodule
